[hw/rtl/lpl_pkg.sv]
// Package for the lookahead peak limiter.
// Holds the configuration register indexes, the fixed field widths and the reset values.
// No dependencies.
`timescale 1ns / 1ps

package lpl_pkg;

    // Configuration port geometry.
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 24;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ATTACK_COEFF  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_RELEASE_COEFF = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_LOOKAHEAD_LEN = 2'd3;

    // Fixed register and gain widths.
    localparam int THR_W  = 24;
    localparam int COEF_W = 16;
    localparam int GAIN_W = 17;
    localparam int LEN_W  = 10;
    localparam int QUOT_W = 16;

    // Reset values of the threshold and length registers and the unity gain.
    localparam logic [THR_W-1:0]  THRESHOLD_RST = 24'd8388608;
    localparam logic [LEN_W-1:0]  LENGTH_RST    = 10'd64;
    localparam logic [GAIN_W-1:0] UNITY_GAIN    = 17'd65536;

endpackage

[hw/rtl/lpl_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
`timescale 1ns / 1ps

module lpl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 512
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; read data holds while not enabled.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/lookahead_peak_limiter_unit.sv]
// Lookahead peak limiter: top level with control sequencer and arithmetic.
// Depends on lpl_pkg and lpl_ram.
`timescale 1ns / 1ps

// After reset the block zeroes every entry of both sample memories and takes no
// transaction meanwhile; configuration writes are taken at any time. Each input
// transaction then scans a window of the active lookahead length, divides for
// the gain only when the window peak exceeds the threshold, smooths the gain and
// scales the delayed sample: the window maximum is found by reading the magnitude
// memory one entry a cycle, and the gain division is a restoring divider that
// produces one quotient bit a cycle. A result waiting at the output does not
// block acceptance of the next input transaction.
module lookahead_peak_limiter_unit #(
    parameter int LOOKAHEAD_MAX = 512,
    parameter int SAMPLE_BITS   = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lpl_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [lpl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0]  i_sample_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]  o_sample_out,
    output logic [lpl_pkg::GAIN_W-1:0]     o_gain_now,
    output logic [SAMPLE_BITS-1:0]         o_peak_now
);

    import lpl_pkg::*;

    localparam int AW = (LOOKAHEAD_MAX > 1) ? $clog2(LOOKAHEAD_MAX) : 1;
    localparam int LW = $clog2(LOOKAHEAD_MAX + 1);
    localparam int CW = (LW > LEN_W) ? LW : LEN_W;
    localparam int RW = ((SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W) + 1;
    localparam int PW = SAMPLE_BITS + GAIN_W + 1;
    localparam int YW = PW - QUOT_W;
    localparam int DCW = $clog2(QUOT_W);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_SCAN, ST_DRAIN, ST_DIV,
        ST_MUL1, ST_MUL2, ST_OMUL, ST_DONE
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [THR_W-1:0]  r_threshold;
    logic [COEF_W-1:0] r_attack;
    logic [COEF_W-1:0] r_release;
    logic [LEN_W-1:0]  r_length;

    // Datapath registers.
    logic [AW-1:0]                r_pos;
    logic [AW-1:0]                r_pos_use;
    logic [LW-1:0]                r_cnt;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic [SAMPLE_BITS-1:0]       r_peak;
    logic                         r_rdv;
    logic [RW-1:0]                r_rem;
    logic [QUOT_W-1:0]            r_quot;
    logic [DCW-1:0]               r_dcnt;
    logic [GAIN_W-1:0]            r_target;
    logic [GAIN_W-1:0]            r_gain;
    logic [GAIN_W+COEF_W-1:0]     r_p1;
    logic [2*GAIN_W-1:0]          r_p2;
    logic signed [PW-1:0]         r_prod;

    // Active lookahead length, clamped to 1..LOOKAHEAD_MAX.
    logic [CW-1:0] len_c;
    logic [LW-1:0] len_eff;
    always_comb begin
        len_c = CW'(r_length);
        if (len_c == '0) begin
            len_c = CW'(1);
        end else if (len_c > CW'(LOOKAHEAD_MAX)) begin
            len_c = CW'(LOOKAHEAD_MAX);
        end
        len_eff = len_c[LW-1:0];
    end

    // Ring position wraps to zero if the length shrank to or below it.
    logic [AW-1:0] pos_use;
    logic [LW-1:0] pos_inc;
    logic [AW-1:0] pos_next;
    assign pos_use  = (LW'(r_pos) >= len_eff) ? '0 : r_pos;
    assign pos_inc  = LW'(pos_use) + LW'(1);
    assign pos_next = (pos_inc >= len_eff) ? '0 : pos_inc[AW-1:0];

    // Input magnitude; the most negative sample maps to 2^(SAMPLE_BITS-1).
    logic [SAMPLE_BITS-1:0] mag;
    assign mag = i_sample_in[SAMPLE_BITS-1] ? (~i_sample_in + 1'b1) : i_sample_in;

    logic in_fire;
    assign o_in_ready = (r_state == ST_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;

    // Memory ports.
    logic                   mag_we;
    logic [AW-1:0]          mag_waddr;
    logic [SAMPLE_BITS-1:0] mag_wdata;
    logic [SAMPLE_BITS-1:0] mag_rdata;
    logic                   dly_we;
    logic [AW-1:0]          dly_waddr;
    logic [SAMPLE_BITS-1:0] dly_wdata;
    logic [SAMPLE_BITS-1:0] dly_rdata;

    assign mag_we    = (r_state == ST_CLEAR) || in_fire;
    assign mag_waddr = (r_state == ST_CLEAR) ? r_cnt[AW-1:0] : pos_use;
    assign mag_wdata = (r_state == ST_CLEAR) ? '0 : mag;
    assign dly_we    = (r_state == ST_CLEAR) || (r_state == ST_DRAIN);
    assign dly_waddr = (r_state == ST_CLEAR) ? r_cnt[AW-1:0] : r_pos_use;
    assign dly_wdata = (r_state == ST_CLEAR) ? '0 : r_x;

    lpl_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(LOOKAHEAD_MAX)) u_mag_ram (
        .i_clk   (i_clk),
        .i_we    (mag_we),
        .i_waddr (mag_waddr),
        .i_wdata (mag_wdata),
        .i_re    (r_state == ST_SCAN),
        .i_raddr (r_cnt[AW-1:0]),
        .o_rdata (mag_rdata)
    );

    lpl_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(LOOKAHEAD_MAX)) u_dly_ram (
        .i_clk   (i_clk),
        .i_we    (dly_we),
        .i_waddr (dly_waddr),
        .i_wdata (dly_wdata),
        .i_re    (in_fire),
        .i_raddr (pos_use),
        .o_rdata (dly_rdata)
    );

    // Running maximum including the entry that arrives this cycle.
    logic [SAMPLE_BITS-1:0] peak_upd;
    assign peak_upd = (r_rdv && (mag_rdata > r_peak)) ? mag_rdata : r_peak;

    // One restoring division step.
    logic [RW-1:0] rem_sh;
    logic          rem_ge;
    assign rem_sh = {r_rem[RW-2:0], 1'b0};
    assign rem_ge = (rem_sh >= RW'(r_peak));

    // Filter coefficient choice and products.
    logic [COEF_W-1:0] coeff;
    logic [GAIN_W-1:0] coeff_c;
    assign coeff   = (r_target < r_gain) ? r_attack : r_release;
    assign coeff_c = UNITY_GAIN - GAIN_W'(coeff);

    logic [2*GAIN_W:0] gain_sum;
    assign gain_sum = (2*GAIN_W+1)'(r_p1) + (2*GAIN_W+1)'(r_p2);

    // Floor shift and saturation of the output product.
    logic signed [YW-1:0]          y;
    logic signed [SAMPLE_BITS-1:0] y_sat;
    localparam logic signed [YW-1:0] Y_HI = YW'((2 ** (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [YW-1:0] Y_LO = -Y_HI - YW'(1);
    always_comb begin
        y = YW'(r_prod >>> QUOT_W);
        if (y > Y_HI) begin
            y_sat = Y_HI[SAMPLE_BITS-1:0];
        end else if (y < Y_LO) begin
            y_sat = Y_LO[SAMPLE_BITS-1:0];
        end else begin
            y_sat = y[SAMPLE_BITS-1:0];
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_attack    <= '0;
            r_release   <= '0;
            r_length    <= LENGTH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_THRESHOLD:     r_threshold <= i_cfg_data[THR_W-1:0];
                CFG_ATTACK_COEFF:  r_attack    <= i_cfg_data[COEF_W-1:0];
                CFG_RELEASE_COEFF: r_release   <= i_cfg_data[COEF_W-1:0];
                CFG_LOOKAHEAD_LEN: r_length    <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer with the registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_cnt       <= '0;
            r_pos       <= '0;
            r_gain      <= UNITY_GAIN;
            r_rdv       <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            // The done state reloads the output register itself.
            if (o_out_valid && i_out_ready && (r_state != ST_DONE)) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                // Zero both memories once after reset.
                ST_CLEAR: begin
                    if (r_cnt == LW'(LOOKAHEAD_MAX - 1)) begin
                        r_cnt   <= '0;
                        r_state <= ST_IDLE;
                    end else begin
                        r_cnt <= r_cnt + LW'(1);
                    end
                end
                // Take a sample, store its magnitude, fetch the delayed sample.
                ST_IDLE: begin
                    if (in_fire) begin
                        r_x       <= i_sample_in;
                        r_pos_use <= pos_use;
                        r_pos     <= pos_next;
                        r_cnt     <= '0;
                        r_peak    <= '0;
                        r_rdv     <= 1'b0;
                        r_state   <= ST_SCAN;
                    end
                end
                // Read the window one entry a cycle.
                ST_SCAN: begin
                    r_peak <= peak_upd;
                    r_rdv  <= 1'b1;
                    if (r_cnt == len_eff - LW'(1)) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_cnt <= r_cnt + LW'(1);
                    end
                end
                // Last entry arrives; the delay slot takes the new sample.
                ST_DRAIN: begin
                    r_peak <= peak_upd;
                    r_rdv  <= 1'b0;
                    if (RW'(peak_upd) > RW'(r_threshold)) begin
                        r_rem   <= RW'(r_threshold);
                        r_quot  <= '0;
                        r_dcnt  <= '0;
                        r_state <= ST_DIV;
                    end else begin
                        r_target <= UNITY_GAIN;
                        r_state  <= ST_MUL1;
                    end
                end
                // Threshold * 65536 / peak, one quotient bit a cycle.
                ST_DIV: begin
                    r_rem  <= rem_ge ? (rem_sh - RW'(r_peak)) : rem_sh;
                    r_quot <= {r_quot[QUOT_W-2:0], rem_ge};
                    r_dcnt <= r_dcnt + DCW'(1);
                    if (r_dcnt == DCW'(QUOT_W - 1)) begin
                        r_target <= {1'b0, r_quot[QUOT_W-2:0], rem_ge};
                        r_state  <= ST_MUL1;
                    end
                end
                // One-pole smoothing products.
                ST_MUL1: begin
                    r_p1    <= coeff * r_gain;
                    r_p2    <= coeff_c * r_target;
                    r_state <= ST_MUL2;
                end
                ST_MUL2: begin
                    r_gain  <= gain_sum[QUOT_W +: GAIN_W];
                    r_state <= ST_OMUL;
                end
                // Delayed sample times the new gain.
                ST_OMUL: begin
                    r_prod  <= PW'($signed(dly_rdata)) * $signed({1'b0, r_gain});
                    r_state <= ST_DONE;
                end
                // Present the result once the output register is free.
                ST_DONE: begin
                    if (!o_out_valid || i_out_ready) begin
                        o_sample_out <= y_sat;
                        o_gain_now   <= r_gain;
                        o_peak_now   <= r_peak;
                        o_out_valid  <= 1'b1;
                        r_state      <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

[tb/tb_lookahead_peak_limiter_unit.sv]
// Testbench for the lookahead peak limiter: directed and random samples with a
// predictor of the output sample, gain and peak checked against every output transaction.
// Depends on lpl_pkg and lookahead_peak_limiter_unit.
`timescale 1ns / 1ps

module tb_lookahead_peak_limiter_unit;
    import lpl_pkg::*;

    localparam int DEPTH = 512;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic signed [23:0] sample;
        logic [GAIN_W-1:0]  gain;
        logic [23:0]        peak;
    } t_limiter_out;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic signed [23:0]    i_sample_in;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic signed [23:0]    o_sample_out;
    logic [GAIN_W-1:0]     o_gain_now;
    logic [23:0]           o_peak_now;

    lookahead_peak_limiter_unit #(
        .LOOKAHEAD_MAX(DEPTH),
        .SAMPLE_BITS  (24)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_sample_in (i_sample_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_sample_out(o_sample_out),
        .o_gain_now  (o_gain_now),
        .o_peak_now  (o_peak_now)
    );

    // Predictor copy of the registers and the limiter state.
    longint unsigned lim_threshold;
    longint unsigned lim_attack;
    longint unsigned lim_release;
    longint unsigned lim_length;
    longint          delay_line [DEPTH];
    longint unsigned mag_window [DEPTH];
    int unsigned     ring_idx;
    longint unsigned gain_state;

    t_limiter_out expected_outputs[$];
    int errors;
    int samples_sent;
    int outputs_checked;
    int send_idle_pct;
    int recv_idle_pct;
    int stall_cycles;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Computes the limiter output for one sample and advances the predictor.
    task automatic predict_limiter(input logic signed [23:0] x);
        int unsigned     len;
        int unsigned     pos;
        longint          xs;
        longint unsigned mag;
        longint unsigned peak;
        longint unsigned target;
        longint unsigned coeff;
        longint          delayed;
        longint          y;
        t_limiter_out    res;
        len = (lim_length < 1) ? 1 : (lim_length > DEPTH) ? DEPTH : int'(lim_length);
        pos = (ring_idx >= len) ? 0 : ring_idx;
        xs = x;
        mag = (xs < 0) ? longint'(-xs) : longint'(xs);
        mag_window[pos] = mag;
        peak = 0;
        for (int i = 0; i < len; i++) begin
            if (mag_window[i] > peak) peak = mag_window[i];
        end
        if (peak <= lim_threshold) target = 65536;
        else target = (lim_threshold << 16) / peak;
        coeff = (target < gain_state) ? lim_attack : lim_release;
        gain_state = (coeff * gain_state + (65536 - coeff) * target) >> 16;
        delayed = delay_line[pos];
        delay_line[pos] = xs;
        pos++;
        ring_idx = (pos >= len) ? 0 : pos;
        y = (delayed * longint'(gain_state)) >>> 16;
        if (y > 8388607) y = 8388607;
        if (y < -8388608) y = -8388608;
        res.sample = y[23:0];
        res.gain = gain_state[GAIN_W-1:0];
        res.peak = peak[23:0];
        expected_outputs.push_back(res);
    endtask

    // Writes one register; the block is idle whenever this is called.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input int unsigned val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val[CFG_DATA_W-1:0];
        case (idx)
            CFG_THRESHOLD:     lim_threshold = val & 24'hFFFFFF;
            CFG_ATTACK_COEFF:  lim_attack = val & 16'hFFFF;
            CFG_RELEASE_COEFF: lim_release = val & 16'hFFFF;
            CFG_LOOKAHEAD_LEN: lim_length = val & 10'h3FF;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic configure(input int unsigned thr, input int unsigned att,
                             input int unsigned rel, input int unsigned len);
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_ATTACK_COEFF, att);
        write_reg(CFG_RELEASE_COEFF, rel);
        write_reg(CFG_LOOKAHEAD_LEN, len);
    endtask

    // Sends one sample transaction, with random idle cycles before it.
    task automatic send_sample(input logic signed [23:0] x);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample_in <= x;
        do @(posedge i_clk); while (!o_in_ready);
        predict_limiter(x);
        samples_sent++;
        @(negedge i_clk);
    endtask

    // Lets every expected output arrive, then idles further before returning.
    task automatic drain_outputs();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (expected_outputs.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    // Receiver stalls.
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Output checker and stall watchdog.
    always @(posedge i_clk) begin
        t_limiter_out exp_out;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            outputs_checked++;
            if (expected_outputs.size() == 0) begin
                $error("unexpected output transaction: sample_out %0d", o_sample_out);
                errors++;
            end else begin
                exp_out = expected_outputs.pop_front();
                if (o_sample_out !== exp_out.sample) begin
                    $error("sample_out expected %0d actual %0d", exp_out.sample, o_sample_out);
                    errors++;
                end
                if (o_gain_now !== exp_out.gain) begin
                    $error("gain_now expected %0d actual %0d", exp_out.gain, o_gain_now);
                    errors++;
                end
                if (o_peak_now !== exp_out.peak) begin
                    $error("peak_now expected %0d actual %0d", exp_out.peak, o_peak_now);
                    errors++;
                end
            end
        end
        if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout after %0d idle cycles", stall_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Reset values, full-scale samples and the most negative sample.
    task automatic test_reset_defaults();
        send_sample(24'sd8388607);
        send_sample(-24'sd8388608);
        send_sample(24'sd0);
        send_sample(-24'sd1);
        send_sample(24'sd1);
        drain_outputs();
    endtask

    // Hard limiting with threshold zero, instant attack with slow release, then slow attack with instant release.
    task automatic test_limiting();
        configure(0, 0, 0, 4);
        send_sample(24'sd4000000);
        send_sample(-24'sd8388608);
        drain_outputs();
        configure(1000000, 0, 65535, 2);
        send_sample(24'sd8388607);
        send_sample(-24'sd8388608);
        send_sample(24'sd100);
        send_sample(24'sd200);
        drain_outputs();
        configure(1000000, 65535, 0, 2);
        send_sample(24'sd8388607);
        send_sample(24'sd5);
        send_sample(24'sd5);
        drain_outputs();
    endtask

    // Length zero (clamped to one), oversize length and a shrink below the ring position.
    task automatic test_length_cases();
        configure(THRESHOLD_RST, 30000, 60000, 0);
        send_sample(24'sd7000000);
        send_sample(-24'sd3);
        drain_outputs();
        write_reg(CFG_LOOKAHEAD_LEN, 1023);
        send_sample(24'sd12345);
        drain_outputs();
        write_reg(CFG_LOOKAHEAD_LEN, 8);
        for (int i = 0; i < 6; i++) send_sample(24'(i * 1000000 - 3000000));
        drain_outputs();
        write_reg(CFG_LOOKAHEAD_LEN, 3);
        send_sample(-24'sd8388608);
        send_sample(24'sd77);
        drain_outputs();
    endtask

    // Random segments with random settings, mostly short windows.
    task automatic test_random(input int sender_idle, input int receiver_idle, input int count);
        int target_sent;
        int unsigned thr;
        int unsigned len;
        int n;
        logic signed [23:0] x;
        send_idle_pct = sender_idle;
        recv_idle_pct = receiver_idle;
        target_sent = samples_sent + count;
        while (samples_sent < target_sent) begin
            case ($urandom_range(3))
                0: thr = 0;
                1: thr = 8388608;
                default: thr = $urandom_range(8388608);
            endcase
            if ($urandom_range(9) < 8) len = $urandom_range(16, 1);
            else case ($urandom_range(3))
                0: len = 0;
                1: len = 512;
                2: len = 1023;
                default: len = $urandom_range(600, 17);
            endcase
            configure(thr,
                      ($urandom_range(3) == 0) ? 0 : ($urandom_range(2) == 0) ? 65535
                          : $urandom_range(65535),
                      ($urandom_range(3) == 0) ? 0 : ($urandom_range(2) == 0) ? 65535
                          : $urandom_range(65535),
                      len);
            n = (len > 16) ? 8 : 30;
            for (int i = 0; i < n; i++) begin
                // Mix of full-range samples and quiet passages.
                if ($urandom_range(3) == 0) x = 24'($signed($urandom_range(2000)) - 1000);
                else x = 24'($urandom);
                send_sample(x);
            end
            drain_outputs();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_sample_in = '0;
        i_out_ready = 1'b0;
        errors = 0;
        samples_sent = 0;
        outputs_checked = 0;
        stall_cycles = 0;
        send_idle_pct = 15;
        recv_idle_pct = 84;
        lim_threshold = THRESHOLD_RST;
        lim_attack = 0;
        lim_release = 0;
        lim_length = LENGTH_RST;
        foreach (delay_line[i]) delay_line[i] = 0;
        foreach (mag_window[i]) mag_window[i] = 0;
        ring_idx = 0;
        gain_state = UNITY_GAIN;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_limiting();
        test_length_cases();
        test_random(15, 84, 180);
        test_random(84, 15, 180);
        test_random(0, 0, 180);

        $display("Covered %0d samples and %0d checked outputs over thresholds, coefficients",
                 samples_sent, outputs_checked);
        $display("and window lengths from zero to oversize, with stalls on both sides.");
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
